>>> rtl/tfc_pkg.sv
`timescale 1ns / 1ps
package tfc_pkg;
  localparam int unsigned DataWidth = 32;
  localparam int unsigned FractionBits = 16;
  localparam int unsigned CountWidth = 16;
  localparam int unsigned ShownWidth = 16;
  localparam int unsigned CfgIdxWidth = 1;
  localparam int unsigned CfgDataWidth = 2;
  localparam logic [CfgIdxWidth-1:0] CfgCullMode = 1'd0;
  localparam logic [CfgIdxWidth-1:0] CfgInvertWinding = 1'd1;

  localparam logic [1:0] CullNone = 2'd0;
  localparam logic [1:0] CullFront = 2'd1;
  localparam logic [1:0] CullBack = 2'd2;
  localparam logic [1:0] CullBoth = 2'd3;

  // dividend magnitude is 32 bits shifted by the fraction
  localparam int unsigned DivWidth = DataWidth + FractionBits;
  localparam int unsigned DivCntWidth = $clog2(DivWidth + 1);
  // projected coordinate differences and their products
  localparam int unsigned DiffWidth = DataWidth + 1;
  localparam int unsigned ProdWidth = 2 * DiffWidth;
  localparam int unsigned MulCntWidth = $clog2(DiffWidth + 1);

  typedef enum logic [3:0] {
    StIdle, StDivInit, StDivRun, StDivDone, StDiff, StMulInit, StMulRun,
    StCompare, StOut
  } state_e;

  typedef struct packed {
    logic signed [DataWidth-1:0] first_x;
    logic signed [DataWidth-1:0] first_y;
    logic signed [DataWidth-1:0] first_w;
    logic signed [DataWidth-1:0] second_x;
    logic signed [DataWidth-1:0] second_y;
    logic signed [DataWidth-1:0] second_w;
    logic signed [DataWidth-1:0] third_x;
    logic signed [DataWidth-1:0] third_y;
    logic signed [DataWidth-1:0] third_w;
    logic start_batch;
  } tri_t;

  typedef struct packed {
    logic front_facing;
    logic culled;
    logic zero_w_seen;
    logic [ShownWidth-1:0] triangles_seen;
    logic [ShownWidth-1:0] front_seen;
    logic [ShownWidth-1:0] back_seen;
    logic [ShownWidth-1:0] culled_seen;
  } res_t;
endpackage

>>> rtl/tfc_if.sv
`timescale 1ns / 1ps
interface tfc_tri_if;
  import tfc_pkg::*;
  logic valid;
  logic ready;
  tri_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface tfc_res_if;
  import tfc_pkg::*;
  logic valid;
  logic ready;
  res_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

>>> rtl/triangle_facing_cull_classifier.sv
`timescale 1ns / 1ps
// channel   dir  handshake     payload
// tri_in    in   valid/ready   tri_t: three clip-space vertices, start_batch
// res_out   out  valid/ready   res_t: facing, cull, zero w flag, tallies
// cfg       in   cfg_we_i      cfg_idx_i selects cull_mode or invert_winding
//
// one triangle at a time: six restoring divisions (load, 48 shift-subtract
// steps, store) on one shared bit-per-cycle divider, a difference step, two
// shift-add multiplies and a compare step; a new triangle is accepted only
// after the previous one is through
// a finished item waits in the compare state while the previous result is
// still held; tri_in is ready again the cycle after the new result is stored
// reset (async, active low) clears config, tallies and control state
module triangle_facing_cull_classifier (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic [tfc_pkg::CfgIdxWidth-1:0] cfg_idx_i,
  input  logic [tfc_pkg::CfgDataWidth-1:0] cfg_data_i,
  tfc_tri_if.sink tri_in,
  tfc_res_if.source res_out
);
  import tfc_pkg::*;

  state_e state_q, state_d;
  tri_t tri_q;
  logic [1:0] cull_mode_q;
  logic invert_q;
  logic [CountWidth-1:0] tri_cnt_q, front_cnt_q, back_cnt_q, cull_cnt_q;

  // division sequencing: 0..5 = x0,y0,x1,y1,x2,y2
  logic [2:0] div_idx_q;
  logic [DivWidth-1:0] dvd_q;       // shifts quotient bits in from the right
  logic [DataWidth:0] rem_q;
  logic [DataWidth-1:0] dvs_q;
  logic [DivCntWidth-1:0] dcnt_q;
  logic signed [DataWidth-1:0] p_q [6];
  logic zero_w_q;
  logic [1:0] negs_q;

  // area sign: diffs a*b vs c*d
  logic signed [DiffWidth-1:0] da_q, db_q, dc_q, dd_q;
  logic [DiffWidth-1:0] mcand_q, mplier_q;
  logic [ProdWidth-1:0] acc_q, m1_q;
  logic mul_sel_q;
  logic [MulCntWidth-1:0] mcnt_q;

  res_t res_q;
  logic res_valid_q;

  // current division operands
  logic signed [DataWidth-1:0] num_s, den_s;
  always_comb begin
    case (div_idx_q[2:1])
      2'd0: begin num_s = div_idx_q[0] ? tri_q.first_y : tri_q.first_x;
        den_s = tri_q.first_w; end
      2'd1: begin num_s = div_idx_q[0] ? tri_q.second_y : tri_q.second_x;
        den_s = tri_q.second_w; end
      default: begin num_s = div_idx_q[0] ? tri_q.third_y : tri_q.third_x;
        den_s = tri_q.third_w; end
    endcase
  end

  logic [DataWidth-1:0] num_mag, den_mag;
  assign num_mag = num_s[DataWidth-1] ? DataWidth'(-num_s) : num_s;
  assign den_mag = den_s[DataWidth-1] ? DataWidth'(-den_s) : den_s;

  // one restoring step
  logic [DataWidth+1:0] rem_sh, rem_sub;
  assign rem_sh = {rem_q, dvd_q[DivWidth-1]};
  assign rem_sub = rem_sh - {2'b00, dvs_q};

  // saturate and sign the finished quotient
  logic div_neg;
  logic signed [DataWidth-1:0] quot_s;
  assign div_neg = num_s[DataWidth-1] ^ den_s[DataWidth-1];
  always_comb begin
    if (den_s == '0) begin
      quot_s = '0;
    end else if (div_neg) begin
      if (dvd_q[DivWidth-1:DataWidth-1] != '0) quot_s = {1'b1, {(DataWidth-1){1'b0}}};
      else quot_s = DataWidth'(-dvd_q[DataWidth-1:0]);
    end else begin
      if (dvd_q[DivWidth-1:DataWidth-1] != '0) quot_s = {1'b0, {(DataWidth-1){1'b1}}};
      else quot_s = dvd_q[DataWidth-1:0];
    end
  end

  // sign of the two products
  function automatic logic [1:0] sgn2(input logic signed [DiffWidth-1:0] v);
    sgn2 = v[DiffWidth-1] ? 2'b11 : (v == '0 ? 2'b00 : 2'b01);
  endfunction
  function automatic logic [DiffWidth-1:0] magf(input logic signed [DiffWidth-1:0] v);
    magf = v[DiffWidth-1] ? DiffWidth'(-v) : v;
  endfunction

  logic signed [2:0] s1, s2, sgn_area, sgn_fin;
  always_comb begin
    s1 = $signed(sgn2(da_q)) * $signed(sgn2(db_q));
    s2 = $signed(sgn2(dc_q)) * $signed(sgn2(dd_q));
    if (s1 != s2) sgn_area = (s1 > s2) ? 3'sd1 : -3'sd1;
    else if (s1 == 0) sgn_area = 3'sd0;
    else if (m1_q == acc_q) sgn_area = 3'sd0;
    else sgn_area = ((m1_q > acc_q) ^ (s1 < 0)) ? 3'sd1 : -3'sd1;
    sgn_fin = (negs_q[0] ^ invert_q) ? -sgn_area : sgn_area;
  end

  logic front_w, cull_w;
  always_comb begin
    front_w = sgn_fin < 0;
    case (cull_mode_q)
      CullFront: cull_w = sgn_fin <= 0;
      CullBack: cull_w = sgn_fin >= 0;
      CullBoth: cull_w = 1'b1;
      default: cull_w = 1'b0;
    endcase
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle: if (tri_in.valid) state_d = StDivInit;
      StDivInit: state_d = StDivRun;
      StDivRun: if (dcnt_q == DivCntWidth'(DivWidth - 1)) state_d = StDivDone;
      StDivDone: state_d = (div_idx_q == 3'd5) ? StDiff : StDivInit;
      StDiff: state_d = StMulInit;
      StMulInit: state_d = StMulRun;
      StMulRun: if (mcnt_q == MulCntWidth'(DiffWidth - 1))
        state_d = mul_sel_q ? StCompare : StMulInit;
      StCompare: if (!res_valid_q) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  assign tri_in.ready = (state_q == StIdle);
  assign res_out.valid = res_valid_q;
  assign res_out.payload = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cull_mode_q <= CullNone;
      invert_q <= 1'b0;
      tri_cnt_q <= '0; front_cnt_q <= '0; back_cnt_q <= '0; cull_cnt_q <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgCullMode: cull_mode_q <= cfg_data_i[1:0];
          CfgInvertWinding: invert_q <= cfg_data_i[0];
          default: ;
        endcase
      end
      if (res_out.ready) res_valid_q <= 1'b0;
      if (state_q == StCompare && !res_valid_q) begin
        logic [CountWidth-1:0] t, f, b, c;
        t = tri_q.start_batch ? '0 : tri_cnt_q;
        f = tri_q.start_batch ? '0 : front_cnt_q;
        b = tri_q.start_batch ? '0 : back_cnt_q;
        c = tri_q.start_batch ? '0 : cull_cnt_q;
        if (~&t) t = t + 1'b1;
        if (front_w && ~&f) f = f + 1'b1;
        if (!front_w && ~&b) b = b + 1'b1;
        if (cull_w && ~&c) c = c + 1'b1;
        tri_cnt_q <= t; front_cnt_q <= f; back_cnt_q <= b; cull_cnt_q <= c;
        res_valid_q <= 1'b1;
        res_q.front_facing <= front_w;
        res_q.culled <= cull_w;
        res_q.zero_w_seen <= zero_w_q;
        res_q.triangles_seen <= t;
        res_q.front_seen <= f;
        res_q.back_seen <= b;
        res_q.culled_seen <= c;
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      StIdle: begin
        tri_q <= tri_in.payload;
        div_idx_q <= '0;
        zero_w_q <= 1'b0;
        negs_q <= '0;
        mul_sel_q <= 1'b0;
      end
      StDivInit: begin
        dvd_q <= {num_mag, {FractionBits{1'b0}}};
        dvs_q <= den_mag;
        rem_q <= '0;
        dcnt_q <= '0;
      end
      StDivRun: begin
        dcnt_q <= dcnt_q + 1'b1;
        if (!rem_sub[DataWidth+1]) begin
          rem_q <= rem_sub[DataWidth:0];
          dvd_q <= {dvd_q[DivWidth-2:0], 1'b1};
        end else begin
          rem_q <= rem_sh[DataWidth:0];
          dvd_q <= {dvd_q[DivWidth-2:0], 1'b0};
        end
      end
      StDivDone: begin
        p_q[div_idx_q] <= quot_s;
        div_idx_q <= div_idx_q + 1'b1;
        if (div_idx_q[0]) begin
          if (den_s == '0) zero_w_q <= 1'b1;
          else if (den_s[DataWidth-1]) negs_q <= negs_q + 1'b1;
        end
      end
      StDiff: begin
        // a = p1x-p2x, b = p3y-p2y, c = p1y-p2y, d = p3x-p2x
        da_q <= DiffWidth'(p_q[0]) - DiffWidth'(p_q[2]);
        db_q <= DiffWidth'(p_q[5]) - DiffWidth'(p_q[3]);
        dc_q <= DiffWidth'(p_q[1]) - DiffWidth'(p_q[3]);
        dd_q <= DiffWidth'(p_q[4]) - DiffWidth'(p_q[2]);
      end
      StMulInit: begin
        mcand_q <= mul_sel_q ? magf(dc_q) : magf(da_q);
        mplier_q <= mul_sel_q ? magf(dd_q) : magf(db_q);
        acc_q <= '0;
        mcnt_q <= '0;
      end
      StMulRun: begin
        // msb-first shift-add
        logic [ProdWidth-1:0] nx;
        nx = {acc_q[ProdWidth-2:0], 1'b0};
        if (mplier_q[DiffWidth-1]) nx = nx + ProdWidth'(mcand_q);
        acc_q <= nx;
        mplier_q <= {mplier_q[DiffWidth-2:0], 1'b0};
        mcnt_q <= mcnt_q + 1'b1;
        if (mcnt_q == MulCntWidth'(DiffWidth - 1) && !mul_sel_q) begin
          m1_q <= nx;
          mul_sel_q <= 1'b1;
        end
      end
      default: ;
    endcase
  end
endmodule

>>> dv/triangle_facing_cull_classifier_tb.sv
`timescale 1ns / 1ps
module triangle_facing_cull_classifier_tb;
  import tfc_pkg::*;

  localparam int unsigned StallLimit = 20000;
  localparam logic signed [31:0] MaxPos = 32'sh7fffffff;
  localparam logic signed [31:0] MaxNeg = 32'sh80000000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxWidth-1:0] cfg_idx_i = '0;
  logic [CfgDataWidth-1:0] cfg_data_i = '0;

  tfc_tri_if tri_in ();
  tfc_res_if res_out ();

  triangle_facing_cull_classifier dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .tri_in(tri_in.sink), .res_out(res_out.source)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // predictor copy of the block's configuration and batch tallies
  logic [1:0] mode_q = CullNone;
  logic invert_q = 1'b0;
  logic [CountWidth-1:0] tri_cnt = '0, front_cnt = '0, back_cnt = '0, cull_cnt = '0;

  tri_t pending_tris[$];
  res_t expected_res[$];
  int unsigned fail_count = 0;
  int unsigned accepted = 0;
  int unsigned idle_cycles = 0;
  bit quiet_phase = 1'b0;
  bit in_taken = 1'b0;

  // fixed-point x / w, truncated toward zero and clamped to 32 bits
  function automatic logic signed [63:0] project_coord(logic signed [31:0] num,
                                                      logic signed [31:0] den);
    logic [63:0] nmag, dmag, quo;
    logic neg;
    nmag = num < 0 ? -64'(num) : 64'(num);
    dmag = den < 0 ? -64'(den) : 64'(den);
    quo = (nmag << FractionBits) / dmag;
    neg = (num < 0) != (den < 0);
    if (neg) return quo >= 64'h8000_0000 ? -64'sh8000_0000 : -$signed(quo);
    return quo > 64'h7fff_ffff ? 64'sh7fff_ffff : $signed(quo);
  endfunction

  function automatic logic [CountWidth-1:0] sat_inc(logic [CountWidth-1:0] v);
    return &v ? v : v + 1'b1;
  endfunction

  // classify one triangle and advance the batch tallies
  task automatic classify_triangle(input tri_t t);
    logic signed [31:0] xs[3], ys[3], ws[3];
    logic signed [63:0] px[3], py[3];
    logic signed [127:0] area;
    int negs;
    logic zero_w, front, cull;
    res_t r;
    negs = 0;
    zero_w = 1'b0;
    xs = '{t.first_x, t.second_x, t.third_x};
    ys = '{t.first_y, t.second_y, t.third_y};
    ws = '{t.first_w, t.second_w, t.third_w};
    for (int i = 0; i < 3; i++) begin
      if (ws[i] == 0) begin
        zero_w = 1'b1;
        px[i] = 0;
        py[i] = 0;
      end else begin
        px[i] = project_coord(xs[i], ws[i]);
        py[i] = project_coord(ys[i], ws[i]);
        if (ws[i] < 0) negs++;
      end
    end
    area = 128'(px[0] - px[1]) * 128'(py[2] - py[1])
         - 128'(py[0] - py[1]) * 128'(px[2] - px[1]);
    if ((negs % 2) == 1) area = -area;
    if (invert_q) area = -area;
    front = area < 0;
    case (mode_q)
      CullFront: cull = area <= 0;
      CullBack:  cull = area >= 0;
      CullBoth:  cull = 1'b1;
      default:   cull = 1'b0;
    endcase
    if (t.start_batch) begin
      tri_cnt = '0;
      front_cnt = '0;
      back_cnt = '0;
      cull_cnt = '0;
    end
    tri_cnt = sat_inc(tri_cnt);
    if (front) front_cnt = sat_inc(front_cnt);
    else back_cnt = sat_inc(back_cnt);
    if (cull) cull_cnt = sat_inc(cull_cnt);
    r.front_facing = front;
    r.culled = cull;
    r.zero_w_seen = zero_w;
    r.triangles_seen = tri_cnt;
    r.front_seen = front_cnt;
    r.back_seen = back_cnt;
    r.culled_seen = cull_cnt;
    expected_res.push_back(r);
  endtask

  // driver: new item or random gap at each falling edge
  initial begin
    tri_in.valid = 1'b0;
    tri_in.payload = '0;
    res_out.ready = 1'b0;
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (tri_in.valid && !in_taken) begin
        // hold the item until it is taken
      end else if (pending_tris.size() > 0 && (quiet_phase || $urandom_range(99) >= 20)) begin
        tri_in.payload <= pending_tris.pop_front();
        tri_in.valid <= 1'b1;
      end else begin
        tri_in.valid <= 1'b0;
      end
      res_out.ready <= quiet_phase || $urandom_range(99) >= 20;
    end
  end

  // monitor: accepted items and returned results at the rising edge
  always @(posedge clk_i) begin
    if (rst_ni) begin
      in_taken <= tri_in.valid && tri_in.ready;
      if ((tri_in.valid && tri_in.ready) || (res_out.valid && res_out.ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (tri_in.valid && tri_in.ready) begin
        classify_triangle(tri_in.payload);
        accepted <= accepted + 1;
      end
      if (res_out.valid && res_out.ready) begin
        if (expected_res.size() == 0) begin
          $error("result with nothing expected");
          fail_count++;
        end else begin
          res_t e, a;
          e = expected_res.pop_front();
          a = res_out.payload;
          if (a.front_facing !== e.front_facing) begin
            $error("front_facing exp %0d got %0d", e.front_facing, a.front_facing);
            fail_count++;
          end
          if (a.culled !== e.culled) begin
            $error("culled exp %0d got %0d", e.culled, a.culled);
            fail_count++;
          end
          if (a.zero_w_seen !== e.zero_w_seen) begin
            $error("zero_w_seen exp %0d got %0d", e.zero_w_seen, a.zero_w_seen);
            fail_count++;
          end
          if (a.triangles_seen !== e.triangles_seen) begin
            $error("triangles_seen exp %0d got %0d", e.triangles_seen, a.triangles_seen);
            fail_count++;
          end
          if (a.front_seen !== e.front_seen) begin
            $error("front_seen exp %0d got %0d", e.front_seen, a.front_seen);
            fail_count++;
          end
          if (a.back_seen !== e.back_seen) begin
            $error("back_seen exp %0d got %0d", e.back_seen, a.back_seen);
            fail_count++;
          end
          if (a.culled_seen !== e.culled_seen) begin
            $error("culled_seen exp %0d got %0d", e.culled_seen, a.culled_seen);
            fail_count++;
          end
        end
      end
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk_i) begin
    if (idle_cycles > StallLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // random coordinate biased toward extremes and small values
  function automatic logic signed [31:0] rand_coord();
    case ($urandom_range(9))
      0: return MaxPos;
      1: return MaxNeg;
      2: return 32'($urandom_range(0, 4)) - 2;
      3, 4: return $signed(32'($urandom_range(0, 32'h0008_0000))) - 32'sh0004_0000;
      default: return $signed($urandom());
    endcase
  endfunction

  function automatic logic signed [31:0] rand_w();
    case ($urandom_range(11))
      0: return 0;
      1: return 1;
      2: return -1;
      3: return MaxPos;
      4: return MaxNeg;
      5, 6: return $urandom_range(1) ? 32'sh0001_0000 : -32'sh0001_0000;
      default: return rand_coord();
    endcase
  endfunction

  function automatic tri_t rand_tri();
    tri_t t;
    t.first_x = rand_coord();
    t.first_y = rand_coord();
    t.first_w = rand_w();
    t.second_x = rand_coord();
    t.second_y = rand_coord();
    t.second_w = rand_w();
    t.third_x = rand_coord();
    t.third_y = rand_coord();
    t.third_w = rand_w();
    t.start_batch = $urandom_range(29) == 0;
    return t;
  endfunction

  function automatic tri_t make_tri(logic signed [31:0] ax, ay, aw, bx, by, bw,
                                    cx, cy, cw, logic sb);
    tri_t t;
    t = '{ax, ay, aw, bx, by, bw, cx, cy, cw, sb};
    return t;
  endfunction

  // block is idle: wait until every result is back, then a margin
  task automatic wait_drained();
    while (pending_tris.size() > 0 || tri_in.valid || expected_res.size() > 0)
      @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CfgIdxWidth-1:0] idx, logic [CfgDataWidth-1:0] val);
    @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_idx_i = idx;
    cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx == CfgCullMode) mode_q = val;
    else invert_q = val[0];
  endtask

  localparam logic signed [31:0] One = 32'sh0001_0000;

  initial begin
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // directed: windings, zero area, zero w, negative w, saturation, batch clear
    pending_tris.push_back(make_tri(0, 0, One, One, 0, One, 0, One, One, 1'b1));
    pending_tris.push_back(make_tri(0, 0, One, 0, One, One, One, 0, One, 1'b0));
    pending_tris.push_back(make_tri(0, 0, One, One, One, One, 2*One, 2*One, One, 1'b0));
    pending_tris.push_back(make_tri(0, 0, -One, One, 0, One, 0, One, One, 1'b0));
    pending_tris.push_back(make_tri(0, 0, -One, One, 0, -One, 0, One, One, 1'b0));
    pending_tris.push_back(make_tri(One, One, 0, One, 0, One, 0, One, One, 1'b0));
    pending_tris.push_back(make_tri(MaxPos, MaxNeg, 1, MaxNeg, MaxPos, 1,
                                    MaxPos, MaxPos, -1, 1'b0));
    pending_tris.push_back(make_tri(MaxNeg, MaxNeg, MaxNeg, MaxPos, MaxPos, MaxPos,
                                    MaxNeg, MaxPos, MaxPos, 1'b0));
    pending_tris.push_back(make_tri(-1, -1, -1, 32'shffff_ffff, 0, 0, 0, 0, 0, 1'b0));
    pending_tris.push_back(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0, 1'b1));
    wait_drained();

    // sweep every cull mode against both windings with random triangles
    for (int ph = 0; ph < 8; ph++) begin
      write_reg(CfgCullMode, ph[1:0]);
      write_reg(CfgInvertWinding, CfgDataWidth'(ph[2]));
      quiet_phase = (ph == 5);
      if (ph < 2) begin
        pending_tris.push_back(make_tri(0, 0, One, One, 0, One, 0, One, One, 1'b0));
        pending_tris.push_back(make_tri(0, 0, One, 0, One, One, One, 0, One, 1'b0));
        pending_tris.push_back(make_tri(0, 0, One, One, One, One, 2*One, 2*One, One, 1'b0));
      end
      for (int n = 0; n < 142; n++) pending_tris.push_back(rand_tri());
      wait_drained();
    end
    quiet_phase = 1'b0;

    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
